@@ design/assert_macros.svh @@
// Assertion helpers for the vector-to-angles block.
// Both expect clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge out of reset
`define VTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true out of reset
`define VTA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define VTA_ASSERT(lbl, prop, msg)
`define VTA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ design/vta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vta_pkg;

    // iteration count and the atan table it draws from
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NSTG          = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int SW            = $clog2(TABLE_LEN);

    // datapath widths: components are integer*2^14, angles degrees*65536
    localparam int DW = 34;
    localparam int AW = 26;
    localparam int CW = 18;

    localparam int DEG_UNIT  = 65536;
    localparam int FULL_CODE = 46080;
    localparam int MAX_CODE  = 46079;

    // 1/K in Q30
    localparam logic [29:0] INVK_Q30 = 30'd652032874;

    localparam logic signed [AW-1:0] ANG_90  = AW'(90 * DEG_UNIT);
    localparam logic signed [AW-1:0] ANG_180 = AW'(180 * DEG_UNIT);

    localparam logic [15:0] CODE_90  = 16'(90 * 128);
    localparam logic [15:0] CODE_270 = 16'(270 * 128);

    // register map
    localparam logic REG_WHOLE_DEGREES = 1'b0;

    localparam logic signed [AW-1:0] ATAN_TAB [TABLE_LEN] = '{
        AW'(2949120), AW'(1740967), AW'(919879), AW'(466945),
        AW'(234379),  AW'(117304),  AW'(58666),  AW'(29335),
        AW'(14668),   AW'(7334),    AW'(3667),   AW'(1833),
        AW'(917),     AW'(458),     AW'(229),    AW'(115),
        AW'(57),      AW'(29),      AW'(14),     AW'(7),
        AW'(4),       AW'(2),       AW'(1),      AW'(0)
    };

    typedef struct packed {
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
    } vta_in_t;

    typedef struct packed {
        logic [15:0] pitch_deg;
        logic [15:0] yaw_deg;
    } vta_out_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] a;
    } cordic_word_t;

    // angle in degrees*65536 to output code; negative angles wrap by 360 degrees, then the code saturates at MAX_CODE
    function automatic logic [15:0] to_code(input logic signed [AW-1:0] a,
                                            input logic whole);
        logic signed [AW-1:0] mag;
        logic signed [AW-1:0] w;
        logic signed [AW:0]   t;
        logic signed [CW-1:0] c;
        mag = a[AW-1] ? -a : a;
        w   = mag >>> 16;
        t   = {a[AW-1], a} + (AW+1)'(256);
        if (whole)
        begin
            if (a[AW-1])
                w = -w;
            c = CW'(w) <<< 7;
        end
        else
        begin
            c = CW'(t >>> 9);
        end
        if (c < 0)
            c = c + CW'(FULL_CODE);
        if (c < 0)
            c = '0;
        if (c >= CW'(FULL_CODE))
            c = CW'(MAX_CODE);
        return c[15:0];
    endfunction

endpackage

`default_nettype wire

@@ design/vta_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vta_cell
    import vta_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic [SW-1:0]        shift,
    input  wire logic signed [AW-1:0] atan_step,
    input  wire logic                 valid_in,
    input  wire cordic_word_t         word_in,
    output logic                      valid_out,
    output cordic_word_t              word_out
);

    logic         valid_reg;
    cordic_word_t word_reg;
    cordic_word_t word_next;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;

    always_comb
    begin
        dx = word_in.y >>> shift;
        dy = word_in.x >>> shift;
        // rotate toward y = 0
        if (!word_in.y[DW-1])
        begin
            word_next.x = word_in.x + dx;
            word_next.y = word_in.y - dy;
            word_next.a = word_in.a + atan_step;
        end
        else
        begin
            word_next.x = word_in.x - dx;
            word_next.y = word_in.y + dy;
            word_next.a = word_in.a - atan_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

`default_nettype wire

@@ design/vta_pass.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vta_pass
    import vta_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         valid_in,
    input  wire cordic_word_t word_in,
    output logic              valid_out,
    output cordic_word_t      word_out
);

    logic         valid_chain [NSTG+1];
    cordic_word_t word_chain  [NSTG+1];

    assign valid_chain[0] = valid_in;
    assign word_chain[0]  = word_in;

    for (genvar k = 0; k < NSTG; k++)
    begin : g_cell
        vta_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift     (SW'(k)),
            .atan_step (ATAN_TAB[k]),
            .valid_in  (valid_chain[k]),
            .word_in   (word_chain[k]),
            .valid_out (valid_chain[k+1]),
            .word_out  (word_chain[k+1])
        );
    end

    assign valid_out = valid_chain[NSTG];
    assign word_out  = word_chain[NSTG];

endmodule

`default_nettype wire

@@ design/vector_to_angles_core.sv @@
// Yaw and pitch of a signed direction vector, degrees*128, unsigned.
//
// in_valid/in_stall carry one vector word (vec_x, vec_y, vec_z);
// out_valid/out_stall carry one angle word (pitch_deg, yaw_deg) per input.
// A word moves on a rising edge with valid high and stall low.
// The APB port holds whole_degrees at address 0; write it only while idle.
//
// The pipeline is an input register with half-plane folding, one CORDIC
// cell per iteration for yaw, a 31x30 multiply for the 1/K gain
// correction, a second cell row for pitch, and the output register that
// converts both angles to codes.
// Throughput is one vector per cycle while the receiver does not stall; the cell rows advance together.
// When the receiver stalls a waiting result, the whole pipeline freezes
// and in_stall rises; it falls again the cycle the result is taken.
// Reset clears every valid flag and whole_degrees; data registers are
// not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vector_to_angles_core
    import vta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire vta_in_t     in_word,

    output logic             out_valid,
    input  wire logic        out_stall,
    output vta_out_t         out_word,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef struct packed {
        logic               horiz_zero;
        logic               x_zero;
        logic               y_zero;
        logic               x_pos;
        logic               y_pos;
        logic               z_zero;
        logic               z_pos;
        logic signed [15:0] z;
    } side1_t;

    typedef struct packed {
        logic                 horiz_zero;
        logic                 z_zero;
        logic                 z_pos;
        logic signed [AW-1:0] yaw;
    } side2_t;

    logic whole_reg;
    logic en;
    logic out_valid_reg;

    // ---- config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WHOLE_DEGREES) ? {31'b0, whole_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            whole_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_WHOLE_DEGREES))
            whole_reg <= pwdata[0];
    end

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---- input stage: flags and half-plane folding
    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] sy;
    cordic_word_t         pre_next;
    side1_t               side_next;
    logic                 pre_valid_reg;
    cordic_word_t         pre_word_reg;
    side1_t               pre_side_reg;

    always_comb
    begin
        sx = {{(DW-30){in_word.vec_x[15]}}, in_word.vec_x, 14'b0};
        sy = {{(DW-30){in_word.vec_y[15]}}, in_word.vec_y, 14'b0};
        pre_next.x = sx;
        pre_next.y = sy;
        pre_next.a = '0;
        if (in_word.vec_x[15])
        begin
            if (!in_word.vec_y[15])
            begin
                pre_next.x = sy;
                pre_next.y = -sx;
                pre_next.a = ANG_90;
            end
            else
            begin
                pre_next.x = -sy;
                pre_next.y = sx;
                pre_next.a = -ANG_90;
            end
        end
        side_next.x_zero     = (in_word.vec_x == 16'sd0);
        side_next.y_zero     = (in_word.vec_y == 16'sd0);
        side_next.horiz_zero = side_next.x_zero && side_next.y_zero;
        side_next.x_pos      = !in_word.vec_x[15] && !side_next.x_zero;
        side_next.y_pos      = !in_word.vec_y[15] && !side_next.y_zero;
        side_next.z_zero     = (in_word.vec_z == 16'sd0);
        side_next.z_pos      = !in_word.vec_z[15] && !side_next.z_zero;
        side_next.z          = in_word.vec_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (en)
            pre_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_word_reg <= pre_next;
            pre_side_reg <= side_next;
        end
    end

    // ---- yaw pass
    logic         p1_valid;
    cordic_word_t p1_word;
    side1_t       side1_line_reg [NSTG];

    vta_pass u_pass_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pre_valid_reg),
        .word_in   (pre_word_reg),
        .valid_out (p1_valid),
        .word_out  (p1_word)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_line_reg[0] <= pre_side_reg;
            for (int k = 1; k < NSTG; k++)
                side1_line_reg[k] <= side1_line_reg[k-1];
        end
    end

    // ---- gain correction and yaw axis cases
    logic [61:0]          prod;
    logic signed [AW-1:0] yaw_next;
    side1_t               s1;
    logic                 mul_valid_reg;
    logic [31:0]          h_reg;
    side2_t               mul_side_reg;

    assign s1   = side1_line_reg[NSTG-1];
    // x is non-negative and below 2^31 here
    assign prod = {31'b0, p1_word.x[30:0]} * {32'b0, INVK_Q30};

    always_comb
    begin
        if (s1.y_zero)
            yaw_next = s1.x_pos ? '0 : ANG_180;
        else if (s1.x_zero)
            yaw_next = s1.y_pos ? ANG_90 : -ANG_90;
        else
            yaw_next = p1_word.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (en)
            mul_valid_reg <= p1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg                   <= prod[61:30];
            mul_side_reg.horiz_zero <= s1.horiz_zero;
            mul_side_reg.z_zero     <= s1.z_zero;
            mul_side_reg.z_pos      <= s1.z_pos;
            mul_side_reg.yaw        <= yaw_next;
        end
    end

    // ---- pitch pass
    cordic_word_t p2_in;
    logic         p2_valid;
    cordic_word_t p2_word;
    side2_t       side2_line_reg [NSTG];
    logic [15:0]  mul_z_unused;

    // z rides one more register alongside the multiplier
    logic signed [15:0] s2_z;
    logic signed [15:0] z_dly_reg;

    assign mul_z_unused = '0;
    assign p2_in.x = {{(DW-32){1'b0}}, h_reg};
    assign p2_in.y = {{(DW-30){s2_z[15]}}, s2_z, 14'b0};
    assign p2_in.a = '0;

    always_ff @(posedge clk)
    begin
        if (en)
            z_dly_reg <= s1.z | mul_z_unused;
    end

    assign s2_z = z_dly_reg;

    vta_pass u_pass_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (mul_valid_reg),
        .word_in   (p2_in),
        .valid_out (p2_valid),
        .word_out  (p2_word)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_line_reg[0] <= mul_side_reg;
            for (int k = 1; k < NSTG; k++)
                side2_line_reg[k] <= side2_line_reg[k-1];
        end
    end

    // ---- output register
    side2_t   s2;
    vta_out_t out_next;
    vta_out_t out_word_reg;

    assign s2 = side2_line_reg[NSTG-1];

    always_comb
    begin
        if (s2.horiz_zero)
        begin
            out_next.pitch_deg = s2.z_pos ? CODE_90 : CODE_270;
            out_next.yaw_deg   = '0;
        end
        else
        begin
            out_next.pitch_deg = s2.z_zero ? 16'd0 : to_code(p2_word.a, whole_reg);
            out_next.yaw_deg   = to_code(s2.yaw, whole_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= p2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_word_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `VTA_ASSERT(a_yaw_mag_fits, p1_valid && !s1.horiz_zero |-> (p1_word.x[DW-1:31] == '0), "yaw magnitude outside multiplier range")
    `VTA_ASSERT(a_result_kept, out_valid_reg && out_stall |=> out_valid_reg, "stalled result dropped")
    `VTA_ASSERT_NEVER(a_code_range, out_valid_reg && ((out_word_reg.pitch_deg > 16'(MAX_CODE)) || (out_word_reg.yaw_deg > 16'(MAX_CODE))), "angle code at or above 360 degrees")
    `VTA_ASSERT(a_pitch_mag_pos, p2_valid && !s2.horiz_zero |-> !p2_word.x[DW-1], "pitch magnitude went negative")

endmodule

`default_nettype wire
